// ----- design/qalu_pkg.sv -----
// ----------------------------------------------------------------------------
// qalu_pkg: shared types of the quaternion alu
// Opcode encoding and the control word that travels along the divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package qalu_pkg;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_DOT = 2'd1,
    CMD_INV = 2'd2,
    CMD_NOP = 2'd3
  } qalu_cmd_e;

  typedef struct packed {
    qalu_cmd_e  cmd;
    logic       zero_norm;
    logic [3:0] neg;
    logic [3:0] ovf;
  } qalu_ctrl_t;

endpackage

`default_nettype wire

// ----- design/qalu_div_step.sv -----
// ----------------------------------------------------------------------------
// qalu_div_step: one restoring division step for four lanes
// Shifts in one numerator bit per lane, subtracts the shared divisor when it
// fits and shifts the quotient bit in. Output registers advance on en_i.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_div_step #(
  parameter int DW  = 34,
  parameter int QB  = 17,
  parameter int PDW = 65
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire qalu_pkg::qalu_ctrl_t   ctrl_i,
  input  wire logic [PDW-1:0]         pd_i,
  input  wire logic [DW-1:0]          den_i,
  input  wire logic [3:0][DW-1:0]     rem_i,
  input  wire logic [3:0][QB-1:0]     nlo_i,
  input  wire logic [3:0][QB-1:0]     q_i,
  output logic                        valid_o,
  output qalu_pkg::qalu_ctrl_t        ctrl_o,
  output logic [PDW-1:0]              pd_o,
  output logic [DW-1:0]               den_o,
  output logic [3:0][DW-1:0]          rem_o,
  output logic [3:0][QB-1:0]          nlo_o,
  output logic [3:0][QB-1:0]          q_o
);

  logic [3:0][DW:0]   ext;
  logic [3:0][DW:0]   diff;
  logic [3:0]         fits;
  logic [3:0][DW-1:0] rem_d;
  logic [3:0][QB-1:0] nlo_d;
  logic [3:0][QB-1:0] q_d;
  logic               valid_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ext[l]   = {rem_i[l], nlo_i[l][QB-1]};
      diff[l]  = ext[l] - {1'b0, den_i};
      fits[l]  = ext[l] >= {1'b0, den_i};
      rem_d[l] = fits[l] ? diff[l][DW-1:0] : ext[l][DW-1:0];
      nlo_d[l] = {nlo_i[l][QB-2:0], 1'b0};
      q_d[l]   = {q_i[l][QB-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_o <= ctrl_i;
      pd_o   <= pd_i;
      den_o  <= den_i;
      rem_o  <= rem_d;
      nlo_o  <= nlo_d;
      q_o    <= q_d;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- design/quaternion_alu.sv -----
// throughput: one item per cycle while out_ready_i is high; every opcode takes the same pipeline
// the inverse divider spends one stage per quotient bit (COMP_WIDTH + 1)
// each stage holds until its successor frees, so bubbles close up on a stall
// reset clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// quaternion_alu: pipelined quaternion product, dot product and inverse
// Signed fixed point in and out, results rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_alu #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic signed [COMP_WIDTH-1:0] a_w_i,
  input  wire logic signed [COMP_WIDTH-1:0] a_x_i,
  input  wire logic signed [COMP_WIDTH-1:0] a_y_i,
  input  wire logic signed [COMP_WIDTH-1:0] a_z_i,
  input  wire logic signed [COMP_WIDTH-1:0] b_w_i,
  input  wire logic signed [COMP_WIDTH-1:0] b_x_i,
  input  wire logic signed [COMP_WIDTH-1:0] b_y_i,
  input  wire logic signed [COMP_WIDTH-1:0] b_z_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [COMP_WIDTH-1:0]      r_w_o,
  output logic signed [COMP_WIDTH-1:0]      r_x_o,
  output logic signed [COMP_WIDTH-1:0]      r_y_o,
  output logic signed [COMP_WIDTH-1:0]      r_z_o,
  output logic                              saturated_o,
  output logic                              zero_norm_o
);

  localparam int W   = COMP_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 3;
  localparam int QB  = W + 1;
  localparam int DW  = 2 * W + 2;
  localparam int NW  = ((W + 2 * F + 1) > (2 * W + 1) ? (W + 2 * F + 1) : (2 * W + 1)) + 1;
  localparam int PDW = 4 * W + 1;
  localparam int NST = QB + 5;

  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [SW-1:0] MAXV = SW'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);
  localparam logic [QB-1:0]        LIMN = {{(QB-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  // ---------------- handshake chain
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&vld[NST-1:k]);
  end

  assign in_ready_o = en[0];

  // ---------------- stage 1: multipliers
  logic                  v1_q;
  qalu_pkg::qalu_cmd_e   cmd_in;
  qalu_pkg::qalu_cmd_e   cmd1_q;
  logic signed [W-1:0]   am [4];
  logic signed [W-1:0]   bm [4];
  logic signed [PW-1:0]  p1_d [16];
  logic signed [PW-1:0]  p1_q [16];
  logic signed [W-1:0]   a1_q [4];

  always_comb begin
    cmd_in = qalu_pkg::qalu_cmd_e'(cmd_i);
    am[0] = a_w_i;
    am[1] = a_x_i;
    am[2] = a_y_i;
    am[3] = a_z_i;
    // the inverse needs the squares of a, so b is replaced by a
    bm[0] = (cmd_in == qalu_pkg::CMD_INV) ? a_w_i : b_w_i;
    bm[1] = (cmd_in == qalu_pkg::CMD_INV) ? a_x_i : b_x_i;
    bm[2] = (cmd_in == qalu_pkg::CMD_INV) ? a_y_i : b_y_i;
    bm[3] = (cmd_in == qalu_pkg::CMD_INV) ? a_z_i : b_z_i;
    p1_d[0]  = am[0] * bm[0];
    p1_d[1]  = am[1] * bm[1];
    p1_d[2]  = am[2] * bm[2];
    p1_d[3]  = am[3] * bm[3];
    p1_d[4]  = am[0] * bm[1];
    p1_d[5]  = bm[0] * am[1];
    p1_d[6]  = am[2] * bm[3];
    p1_d[7]  = am[3] * bm[2];
    p1_d[8]  = am[0] * bm[2];
    p1_d[9]  = bm[0] * am[2];
    p1_d[10] = am[3] * bm[1];
    p1_d[11] = am[1] * bm[3];
    p1_d[12] = am[0] * bm[3];
    p1_d[13] = bm[0] * am[3];
    p1_d[14] = am[1] * bm[2];
    p1_d[15] = am[2] * bm[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en[0]) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cmd1_q <= cmd_in;
      p1_q   <= p1_d;
      a1_q   <= am;
    end
  end

  // ---------------- stage 2: sums of four products
  logic                 v2_q;
  qalu_pkg::qalu_cmd_e  cmd2_q;
  logic signed [SW-1:0] e [16];
  logic signed [SW-1:0] s2_d [4];
  logic signed [SW-1:0] s2_q [4];
  logic signed [W-1:0]  a2_q [4];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      e[k] = SW'(p1_q[k]);
    end
    case (cmd1_q)
      qalu_pkg::CMD_MUL: s2_d[0] = e[0] - e[1] - e[2] - e[3] + HALF;
      qalu_pkg::CMD_DOT: s2_d[0] = e[0] + e[1] + e[2] + e[3] + HALF;
      qalu_pkg::CMD_INV: s2_d[0] = e[0] + e[1] + e[2] + e[3];
      default:           s2_d[0] = '0;
    endcase
    s2_d[1] = e[4] + e[5] + e[6] - e[7] + HALF;
    s2_d[2] = e[8] + e[9] + e[10] - e[11] + HALF;
    s2_d[3] = e[12] + e[13] + e[14] - e[15] + HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en[1]) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cmd2_q <= cmd1_q;
      s2_q   <= s2_d;
      a2_q   <= a1_q;
    end
  end

  // ---------------- stage 3: round and clamp, divider operands
  logic                 v3_q;
  qalu_pkg::qalu_cmd_e  cmd3_q;
  logic signed [SW-1:0] t3 [4];
  logic [3:0]           sat3;
  logic [3:0][W-1:0]    r3;
  logic [PDW-1:0]       pd3_d;
  logic [PDW-1:0]       pd3_q;
  logic [2*W:0]         n2;
  logic [W-1:0]         mag [4];
  logic [NW-1:0]        n3_d [4];
  logic [NW-1:0]        n3_q [4];
  logic [3:0]           neg3_d;
  logic [3:0]           neg3_q;
  logic [DW-1:0]        den3_q;
  logic                 zn3_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      t3[l]   = s2_q[l] >>> F;
      sat3[l] = (t3[l] > MAXV) || (t3[l] < MINV);
      if (t3[l] > MAXV) begin
        r3[l] = MAXV[W-1:0];
      end else if (t3[l] < MINV) begin
        r3[l] = MINV[W-1:0];
      end else begin
        r3[l] = t3[l][W-1:0];
      end
    end
    if (cmd2_q == qalu_pkg::CMD_DOT) begin
      pd3_d = {sat3[0], {(3*W){1'b0}}, r3[0]};
    end else begin
      pd3_d = {(|sat3), r3[3], r3[2], r3[1], r3[0]};
    end
    n2 = s2_q[0][2*W:0];
    for (int l = 0; l < 4; l++) begin
      mag[l]  = a2_q[l][W-1] ? unsigned'(-a2_q[l]) : unsigned'(a2_q[l]);
      // rounded quotient: (2*mag*2^(2F) + n2) / (2*n2)
      n3_d[l] = (NW'(mag[l]) << (2 * F + 1)) + NW'(n2);
    end
    neg3_d[0] = a2_q[0][W-1];
    for (int l = 1; l < 4; l++) begin
      neg3_d[l] = !a2_q[l][W-1] && (a2_q[l] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en[2]) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      cmd3_q <= cmd2_q;
      pd3_q  <= pd3_d;
      n3_q   <= n3_d;
      neg3_q <= neg3_d;
      den3_q <= {n2, 1'b0};
      zn3_q  <= (n2 == '0);
    end
  end

  // ---------------- stage 4: divider setup
  logic                  v4_q;
  logic [NW-1:0]         nsh [4];
  logic [3:0]            ovf4;
  logic [3:0][DW-1:0]    rem4_d;
  logic [3:0][QB-1:0]    nlo4_d;
  qalu_pkg::qalu_ctrl_t  ctrl4_q;
  logic [PDW-1:0]        pd4_q;
  logic [DW-1:0]         den4_q;
  logic [3:0][DW-1:0]    rem4_q;
  logic [3:0][QB-1:0]    nlo4_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      nsh[l]    = n3_q[l] >> QB;
      // quotient too large for the step count: saturate later
      ovf4[l]   = nsh[l] >= NW'(den3_q);
      rem4_d[l] = DW'(nsh[l]);
      nlo4_d[l] = n3_q[l][QB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en[3]) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ctrl4_q.cmd       <= cmd3_q;
      ctrl4_q.zero_norm <= zn3_q;
      ctrl4_q.neg       <= neg3_q;
      ctrl4_q.ovf       <= ovf4;
      pd4_q             <= pd3_q;
      den4_q            <= den3_q;
      rem4_q            <= rem4_d;
      nlo4_q            <= nlo4_d;
    end
  end

  // ---------------- divider steps
  logic                 dv_s   [QB+1];
  qalu_pkg::qalu_ctrl_t ctrl_s [QB+1];
  logic [PDW-1:0]       pd_s   [QB+1];
  logic [DW-1:0]        den_s  [QB+1];
  logic [3:0][DW-1:0]   rem_s  [QB+1];
  logic [3:0][QB-1:0]   nlo_s  [QB+1];
  logic [3:0][QB-1:0]   q_s    [QB+1];

  assign dv_s[0]   = v4_q;
  assign ctrl_s[0] = ctrl4_q;
  assign pd_s[0]   = pd4_q;
  assign den_s[0]  = den4_q;
  assign rem_s[0]  = rem4_q;
  assign nlo_s[0]  = nlo4_q;
  assign q_s[0]    = '0;

  for (genvar j = 0; j < QB; j++) begin : g_div
    qalu_div_step #(
      .DW  (DW),
      .QB  (QB),
      .PDW (PDW)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[4+j]),
      .valid_i (dv_s[j]),
      .ctrl_i  (ctrl_s[j]),
      .pd_i    (pd_s[j]),
      .den_i   (den_s[j]),
      .rem_i   (rem_s[j]),
      .nlo_i   (nlo_s[j]),
      .q_i     (q_s[j]),
      .valid_o (dv_s[j+1]),
      .ctrl_o  (ctrl_s[j+1]),
      .pd_o    (pd_s[j+1]),
      .den_o   (den_s[j+1]),
      .rem_o   (rem_s[j+1]),
      .nlo_o   (nlo_s[j+1]),
      .q_o     (q_s[j+1])
    );
  end

  assign vld[0] = v1_q;
  assign vld[1] = v2_q;
  assign vld[2] = v3_q;
  for (genvar j = 0; j <= QB; j++) begin : g_vld
    assign vld[3+j] = dv_s[j];
  end

  // ---------------- output stage
  logic                 out_valid_q;
  logic [QB-1:0]        lim  [4];
  logic [3:0]           over;
  logic [QB-1:0]        qq   [4];
  logic [QB-1:0]        qv   [4];
  logic [3:0][W-1:0]    rf_d;
  logic                 sat_d;
  logic                 zn_d;
  logic [3:0][W-1:0]    rf_q;
  logic                 sat_q;
  logic                 zn_q;

  assign vld[NST-1] = out_valid_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lim[l]  = ctrl_s[QB].neg[l] ? LIMN : LIMN - QB'(1);
      over[l] = ctrl_s[QB].ovf[l] || (q_s[QB][l] > lim[l]);
      qq[l]   = over[l] ? lim[l] : q_s[QB][l];
      qv[l]   = ctrl_s[QB].neg[l] ? (-qq[l]) : qq[l];
    end
    rf_d  = '0;
    sat_d = 1'b0;
    zn_d  = 1'b0;
    case (ctrl_s[QB].cmd)
      qalu_pkg::CMD_MUL, qalu_pkg::CMD_DOT: begin
        rf_d  = pd_s[QB][4*W-1:0];
        sat_d = pd_s[QB][4*W];
      end
      qalu_pkg::CMD_INV: begin
        if (ctrl_s[QB].zero_norm) begin
          zn_d = 1'b1;
        end else begin
          for (int l = 0; l < 4; l++) begin
            rf_d[l] = qv[l][W-1:0];
          end
          sat_d = |over;
        end
      end
      default: begin
        rf_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[NST-1]) begin
      out_valid_q <= dv_s[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      rf_q  <= rf_d;
      sat_q <= sat_d;
      zn_q  <= zn_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign r_w_o       = rf_q[0];
  assign r_x_o       = rf_q[1];
  assign r_y_o       = rf_q[2];
  assign r_z_o       = rf_q[3];
  assign saturated_o = sat_q;
  assign zero_norm_o = zn_q;

  // ---------------- checks
  a_zero_norm_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> !saturated_o && r_w_o == '0 && r_x_o == '0
      && r_y_o == '0 && r_z_o == '0)
    else $error("zero norm result carries data or saturation");

  a_transfer_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld[0])
    else $error("accepted transfer missing from first stage");

  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ready_i && (&vld) |-> !in_ready_o)
    else $error("full stalled pipeline still takes input");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rf_q))
    else $error("stalled result lost");

endmodule

`default_nettype wire
